// ----- rtl/nrcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nrcw_pkg;

  localparam int WORD_W = 32;
  localparam int MSS_W  = 16;
  localparam int THR_W  = 4;
  localparam int DUP_W  = 16;
  localparam int OP_W   = 2;
  localparam int M3_W   = MSS_W + 2;
  localparam int CFG_W  = MSS_W;
  localparam int IDX_W  = 1;

  localparam logic [OP_W-1:0] OP_NEW_ACK = 2'd0;
  localparam logic [OP_W-1:0] OP_DUP_ACK = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [IDX_W-1:0] REG_MSS    = 1'd0;
  localparam logic [IDX_W-1:0] REG_DUPTHR = 1'd1;

  localparam logic [MSS_W-1:0] MSS_RESET = 16'd1460;
  localparam logic [THR_W-1:0] THR_RESET = 4'd3;

  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nrcw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrcw_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   dividend,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   divisor,
  output logic      [nrcw_pkg::WORD_W-1:0]   quotient,
  output nrcw_pkg::div_stat_t                stat
);

  localparam int W = nrcw_pkg::WORD_W;
  localparam logic [nrcw_pkg::DIV_CNT_W-1:0] LAST_STEP =
    nrcw_pkg::DIV_CNT_W'(nrcw_pkg::DIV_STEPS - 1);

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] dvs_r;
  logic [nrcw_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  logic [W:0]   shifted;
  logic [W+1:0] trial;
  logic         fits;

  // One quotient bit per cycle: the dividend shifts out of the top of the
  // quotient register while quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = ~trial[W+1];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ----- rtl/newreno_congestion_window_top.sv -----
// Channel  | Handshake           | Beat
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_stall | operation, sequence values, dup count
// result   | out_valid/out_stall | window, threshold, three flags
// config   | cfg_we              | cfg_index, cfg_data (MSS, dup threshold)
//
// One event is worked on at a time. It passes states A and B (then C for
// recovery ACKs, fast retransmit entry and divided increases) on to the
// final state; an unused operation code skips from A to it. A congestion
// avoidance ACK waits on the bit-serial divider (MSS*MSS/cwnd, one bit per cycle).
// in_stall is high from acceptance until the result is loaded into the
// output register; a stalled result holds the block in its final state.
// Synchronous reset restores MSS 1460, threshold 3 and the initial window.
`timescale 1ns / 1ps
`default_nettype none

module newreno_congestion_window_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [nrcw_pkg::OP_W-1:0]     in_operation,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   in_oldest_unacked,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   in_prior_unacked,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   in_highest_sent,
  input  wire logic [nrcw_pkg::WORD_W-1:0]   in_peer_window,
  input  wire logic [nrcw_pkg::DUP_W-1:0]    in_dup_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [nrcw_pkg::WORD_W-1:0]   out_window_bytes,
  output logic      [nrcw_pkg::WORD_W-1:0]   out_threshold_bytes,
  output logic                               out_retransmit_now,
  output logic                               out_restart_timer,
  output logic                               out_in_recovery,
  input  wire logic                          cfg_we,
  input  wire logic [nrcw_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [nrcw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int W = nrcw_pkg::WORD_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_A    = 3'd1;
  localparam logic [2:0] ST_B    = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_C    = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Architectural state and configuration.
  logic [W-1:0] cwnd_r, cwnd_nxt;
  logic [W-1:0] ssth_r, ssth_nxt;
  logic [W-1:0] rp_r, rp_nxt;
  logic         rec_r, rec_nxt;
  logic         ps_r, ps_nxt;
  logic [nrcw_pkg::MSS_W-1:0] mss_r;
  logic [nrcw_pkg::THR_W-1:0] thr_r;

  // Captured event.
  logic [nrcw_pkg::OP_W-1:0]  op_r;
  logic [W-1:0]               una_r, first_r, smax_r, pwnd_r;
  logic [nrcw_pkg::DUP_W-1:0] dups_r;

  // Intermediate values between steps.
  logic [W-1:0]              t1_r, t1_nxt;
  logic [W-1:0]              t2_r, t2_nxt;
  logic [nrcw_pkg::M3_W-1:0] m3_r, m3_nxt;
  logic full_r, full_nxt;
  logic ge_r, ge_nxt;
  logic lt_r, lt_nxt;
  logic zero_r, zero_nxt;
  logic eq_r, eq_nxt;
  logic gt_r, gt_nxt;
  logic rexmit_r, rexmit_nxt;
  logic restart_r, restart_nxt;

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] o_win_r, o_ssth_r;
  logic         o_rexmit_r, o_restart_r, o_rec_r;
  logic         load_out;

  logic         div_start;
  logic [W-1:0] div_q;
  nrcw_pkg::div_stat_t div_stat;

  logic [W-1:0] mss_ext;
  logic [W-1:0] floor2;
  logic [W-1:0] half;
  logic [W-1:0] thr_new;
  logic [nrcw_pkg::DUP_W-1:0] thr_ext;
  logic [W-1:0] rec_span;

  nrcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t1_r),
    .divisor  (cwnd_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    mss_ext = {{(W - nrcw_pkg::MSS_W){1'b0}}, mss_r};
    floor2  = {mss_ext[W-2:0], 1'b0};
    half    = {1'b0, t2_r[W-1:1]};
    thr_new = (half > floor2) ? half : floor2;
    thr_ext = {{(nrcw_pkg::DUP_W - nrcw_pkg::THR_W){1'b0}}, thr_r};
    // una - 1 - recover_point is una + ~recover_point.
    rec_span = una_r + ~rp_r;
  end

  always_comb begin
    state_nxt   = state_r;
    cwnd_nxt    = cwnd_r;
    ssth_nxt    = ssth_r;
    rp_nxt      = rp_r;
    rec_nxt     = rec_r;
    ps_nxt      = ps_r;
    t1_nxt      = t1_r;
    t2_nxt      = t2_r;
    m3_nxt      = m3_r;
    full_nxt    = full_r;
    ge_nxt      = ge_r;
    lt_nxt      = lt_r;
    zero_nxt    = zero_r;
    eq_nxt      = eq_r;
    gt_nxt      = gt_r;
    rexmit_nxt  = rexmit_r;
    restart_nxt = restart_r;
    div_start   = 1'b0;
    load_out    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rexmit_nxt  = 1'b0;
          restart_nxt = 1'b0;
          state_nxt   = ST_A;
        end
      end

      ST_A: begin
        state_nxt = ST_B;
        unique case (op_r)
          nrcw_pkg::OP_NEW_ACK: begin
            if (rec_r) begin
              full_nxt = ~rec_span[W-1];
              t1_nxt   = smax_r - una_r;
              t2_nxt   = una_r - first_r;
            end else begin
              lt_nxt   = cwnd_r < ssth_r;
              zero_nxt = cwnd_r == '0;
              t1_nxt   = mss_ext * mss_ext;
              rp_nxt   = una_r - W'(2);
            end
          end
          nrcw_pkg::OP_DUP_ACK: begin
            eq_nxt = dups_r == thr_ext;
            gt_nxt = dups_r > thr_ext;
            t1_nxt = una_r - W'(1);
            t2_nxt = (cwnd_r < pwnd_r) ? cwnd_r : pwnd_r;
            m3_nxt = {2'b00, mss_r} + {1'b0, mss_r, 1'b0};
          end
          nrcw_pkg::OP_TIMEOUT: begin
            t2_nxt = (cwnd_r < pwnd_r) ? cwnd_r : pwnd_r;
            rp_nxt = smax_r - W'(1);
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_B: begin
        state_nxt = ST_DONE;
        unique case (op_r)
          nrcw_pkg::OP_NEW_ACK: begin
            if (rec_r) begin
              state_nxt = ST_C;
              if (full_r) begin
                t1_nxt = nrcw_pkg::sat_add(t1_r, mss_ext);
              end else begin
                t1_nxt     = (cwnd_r > t2_r) ? (cwnd_r - t2_r) : '0;
                ge_nxt     = t2_r >= mss_ext;
                rexmit_nxt = 1'b1;
                if (!ps_r) begin
                  ps_nxt      = 1'b1;
                  restart_nxt = 1'b1;
                end
              end
            end else if (lt_r) begin
              cwnd_nxt = nrcw_pkg::sat_add(cwnd_r, mss_ext);
            end else if (zero_r) begin
              // A zero window gives a zero quotient, so the increase is one.
              cwnd_nxt = W'(1);
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
          nrcw_pkg::OP_DUP_ACK: begin
            if (eq_r) begin
              if (!rec_r && (t1_r > rp_r)) begin
                ssth_nxt   = thr_new;
                rp_nxt     = smax_r - W'(1);
                ps_nxt     = 1'b0;
                rec_nxt    = 1'b1;
                rexmit_nxt = 1'b1;
                state_nxt  = ST_C;
              end
            end else if (gt_r && rec_r) begin
              cwnd_nxt = nrcw_pkg::sat_add(cwnd_r, mss_ext);
            end
          end
          nrcw_pkg::OP_TIMEOUT: begin
            rec_nxt    = 1'b0;
            ps_nxt     = 1'b0;
            ssth_nxt   = thr_new;
            cwnd_nxt   = mss_ext;
            rexmit_nxt = 1'b1;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_DIV: begin
        if (div_stat.done) begin
          t1_nxt    = (div_q == '0) ? W'(1) : div_q;
          state_nxt = ST_C;
        end
      end

      ST_C: begin
        state_nxt = ST_DONE;
        if (op_r == nrcw_pkg::OP_DUP_ACK) begin
          cwnd_nxt = nrcw_pkg::sat_add(ssth_r,
                       {{(W - nrcw_pkg::M3_W){1'b0}}, m3_r});
        end else if (!rec_r) begin
          cwnd_nxt = nrcw_pkg::sat_add(cwnd_r, t1_r);
        end else if (full_r) begin
          cwnd_nxt = (ssth_r < t1_r) ? ssth_r : t1_r;
          rec_nxt  = 1'b0;
          ps_nxt   = 1'b0;
        end else begin
          cwnd_nxt = ge_r ? nrcw_pkg::sat_add(t1_r, mss_ext) : t1_r;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = (out_valid_r & out_stall) | load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cwnd_r      <= {{(W - nrcw_pkg::MSS_W){1'b0}}, nrcw_pkg::MSS_RESET};
      ssth_r      <= {W{1'b1}};
      rp_r        <= '0;
      rec_r       <= 1'b0;
      ps_r        <= 1'b0;
      mss_r       <= nrcw_pkg::MSS_RESET;
      thr_r       <= nrcw_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cwnd_r      <= cwnd_nxt;
      ssth_r      <= ssth_nxt;
      rp_r        <= rp_nxt;
      rec_r       <= rec_nxt;
      ps_r        <= ps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          nrcw_pkg::REG_MSS:    mss_r <= cfg_data;
          nrcw_pkg::REG_DUPTHR: thr_r <= cfg_data[nrcw_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r    <= in_operation;
      una_r   <= in_oldest_unacked;
      first_r <= in_prior_unacked;
      smax_r  <= in_highest_sent;
      pwnd_r  <= in_peer_window;
      dups_r  <= in_dup_count;
    end
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    m3_r      <= m3_nxt;
    full_r    <= full_nxt;
    ge_r      <= ge_nxt;
    lt_r      <= lt_nxt;
    zero_r    <= zero_nxt;
    eq_r      <= eq_nxt;
    gt_r      <= gt_nxt;
    rexmit_r  <= rexmit_nxt;
    restart_r <= restart_nxt;
    if (load_out) begin
      o_win_r     <= cwnd_r;
      o_ssth_r    <= ssth_r;
      o_rexmit_r  <= rexmit_r;
      o_restart_r <= restart_r;
      o_rec_r     <= rec_r;
    end
  end

  assign in_stall            = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_window_bytes    = o_win_r;
  assign out_threshold_bytes = o_ssth_r;
  assign out_retransmit_now  = o_rexmit_r;
  assign out_restart_timer   = o_restart_r;
  assign out_in_recovery     = o_rec_r;

`ifndef SYNTHESIS
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divider idle while the sequencer waits on it");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_partial_in_rec: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r |-> rec_r)
    else $error("partial ACK mark set outside recovery");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire

// ----- tb/newreno_window_checker.sv -----
`timescale 1ns / 1ps

module newreno_window_checker
  import nrcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [WORD_W-1:0] in_oldest_unacked,
  input  wire logic [WORD_W-1:0] in_prior_unacked,
  input  wire logic [WORD_W-1:0] in_highest_sent,
  input  wire logic [WORD_W-1:0] in_peer_window,
  input  wire logic [DUP_W-1:0]  in_dup_count,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [WORD_W-1:0] out_window_bytes,
  input  wire logic [WORD_W-1:0] out_threshold_bytes,
  input  wire logic              out_retransmit_now,
  input  wire logic              out_restart_timer,
  input  wire logic              out_in_recovery,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output int unsigned            fail_count,
  output int unsigned            outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0] window;
    logic [WORD_W-1:0] threshold;
    logic              retransmit;
    logic              restart;
    logic              recovering;
  } window_report_t;

  window_report_t    window_forecast_q[$];
  logic [WORD_W-1:0] cwnd_now;
  logic [WORD_W-1:0] ssthresh_now;
  logic [WORD_W-1:0] recover_seq;
  logic              fast_recovery;
  logic              partial_acked;
  logic [MSS_W-1:0]  mss_cfg;
  logic [THR_W-1:0]  dupthr_cfg;
  int unsigned       errors = 0;

  function automatic logic [WORD_W-1:0] capped_sum(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] sum;
    sum = a + b;
    return (sum < a) ? '1 : sum;
  endfunction

  // Halve the data in flight, but never below two segments.
  function automatic logic [WORD_W-1:0] backoff_threshold(input logic [WORD_W-1:0] cwnd,
                                                          input logic [WORD_W-1:0] pwnd,
                                                          input logic [MSS_W-1:0]  mss);
    logic [WORD_W-1:0] half_flight;
    logic [WORD_W-1:0] two_segs;
    half_flight = ((cwnd < pwnd) ? cwnd : pwnd) >> 1;
    two_segs    = WORD_W'(mss) << 1;
    return (half_flight > two_segs) ? half_flight : two_segs;
  endfunction

  task automatic advance_window(input logic [OP_W-1:0] op,
                                input logic [WORD_W-1:0] una,
                                input logic [WORD_W-1:0] first,
                                input logic [WORD_W-1:0] smax,
                                input logic [WORD_W-1:0] pwnd,
                                input logic [DUP_W-1:0] dups,
                                output window_report_t rep);
    logic [WORD_W-1:0] mss32;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] acked;
    logic [WORD_W-1:0] flight;
    logic [WORD_W-1:0] step;
    mss32 = WORD_W'(mss_cfg);
    rep = '0;
    case (op)
      OP_NEW_ACK: begin
        if (fast_recovery) begin
          // Serial comparison: the ACK covers the recovery point when the
          // distance past it is not negative.
          span = una - 32'd1 - recover_seq;
          if (!span[WORD_W-1]) begin
            flight = capped_sum(smax - una, mss32);
            cwnd_now = (ssthresh_now < flight) ? ssthresh_now : flight;
            fast_recovery = 1'b0;
            partial_acked = 1'b0;
          end else begin
            acked = una - first;
            rep.retransmit = 1'b1;
            cwnd_now = (cwnd_now > acked) ? cwnd_now - acked : '0;
            if (acked >= mss32) begin
              cwnd_now = capped_sum(cwnd_now, mss32);
            end
            if (!partial_acked) begin
              partial_acked = 1'b1;
              rep.restart = 1'b1;
            end
          end
        end else begin
          if (cwnd_now < ssthresh_now) begin
            cwnd_now = capped_sum(cwnd_now, mss32);
          end else begin
            step = (cwnd_now != '0) ? (mss32 * mss32) / cwnd_now : '0;
            if (step == '0) begin
              step = 32'd1;
            end
            cwnd_now = capped_sum(cwnd_now, step);
          end
          recover_seq = una - 32'd2;
        end
      end
      OP_DUP_ACK: begin
        if (dups == DUP_W'(dupthr_cfg)) begin
          if (!fast_recovery && (una - 32'd1) > recover_seq) begin
            ssthresh_now = backoff_threshold(cwnd_now, pwnd, mss_cfg);
            recover_seq = smax - 32'd1;
            partial_acked = 1'b0;
            fast_recovery = 1'b1;
            cwnd_now = capped_sum(ssthresh_now, 32'd3 * mss32);
            rep.retransmit = 1'b1;
          end
        end else if (dups > DUP_W'(dupthr_cfg)) begin
          if (fast_recovery) begin
            cwnd_now = capped_sum(cwnd_now, mss32);
          end
        end
      end
      OP_TIMEOUT: begin
        recover_seq = smax - 32'd1;
        fast_recovery = 1'b0;
        partial_acked = 1'b0;
        ssthresh_now = backoff_threshold(cwnd_now, pwnd, mss_cfg);
        cwnd_now = mss32;
        rep.retransmit = 1'b1;
      end
      default: begin
      end
    endcase
    rep.window     = cwnd_now;
    rep.threshold  = ssthresh_now;
    rep.recovering = fast_recovery;
  endtask

  task automatic note_field(input string field, input logic [WORD_W-1:0] want,
                            input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    window_report_t want;
    window_report_t got;
    if (!rst_n) begin
      mss_cfg       = MSS_RESET;
      dupthr_cfg    = THR_RESET;
      cwnd_now      = WORD_W'(MSS_RESET);
      ssthresh_now  = '1;
      recover_seq   = '0;
      fast_recovery = 1'b0;
      partial_acked = 1'b0;
      window_forecast_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.window     = out_window_bytes;
        got.threshold  = out_threshold_bytes;
        got.retransmit = out_retransmit_now;
        got.restart    = out_restart_timer;
        got.recovering = out_in_recovery;
        if (window_forecast_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, window %h threshold %h",
                   $time, got.window, got.threshold);
          errors++;
        end else begin
          want = window_forecast_q.pop_front();
          note_field("window_bytes", want.window, got.window);
          note_field("threshold_bytes", want.threshold, got.threshold);
          note_field("retransmit_now", WORD_W'(want.retransmit), WORD_W'(got.retransmit));
          note_field("restart_timer", WORD_W'(want.restart), WORD_W'(got.restart));
          note_field("in_recovery", WORD_W'(want.recovering), WORD_W'(got.recovering));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MSS:    mss_cfg    = cfg_data[MSS_W-1:0];
          REG_DUPTHR: dupthr_cfg = cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_window(in_operation, in_oldest_unacked, in_prior_unacked, in_highest_sent,
                       in_peer_window, in_dup_count, want);
        window_forecast_q = {window_forecast_q, want};
      end
    end
    fail_count  <= errors;
    outstanding <= window_forecast_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import nrcw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  // Covers the slowest event, a congestion avoidance ACK through the divider.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation = '0;
  logic [WORD_W-1:0] in_oldest_unacked = '0;
  logic [WORD_W-1:0] in_prior_unacked = '0;
  logic [WORD_W-1:0] in_highest_sent = '0;
  logic [WORD_W-1:0] in_peer_window = '0;
  logic [DUP_W-1:0]  in_dup_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_window_bytes;
  logic [WORD_W-1:0] out_threshold_bytes;
  logic              out_retransmit_now;
  logic              out_restart_timer;
  logic              out_in_recovery;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int unsigned       fail_count;
  int unsigned       outstanding;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent = 0;
  bit                gaps_on = 1'b1;

  // Sender-side sequence space used to shape well-formed ACK streams.
  logic [MSS_W-1:0]  seg_bytes = MSS_RESET;
  logic [THR_W-1:0]  dup_trigger = THR_RESET;
  logic [WORD_W-1:0] acked_upto = '0;
  logic [WORD_W-1:0] sent_upto = '0;

  newreno_congestion_window_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_oldest_unacked   (in_oldest_unacked),
    .in_prior_unacked    (in_prior_unacked),
    .in_highest_sent     (in_highest_sent),
    .in_peer_window      (in_peer_window),
    .in_dup_count        (in_dup_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_bytes    (out_window_bytes),
    .out_threshold_bytes (out_threshold_bytes),
    .out_retransmit_now  (out_retransmit_now),
    .out_restart_timer   (out_restart_timer),
    .out_in_recovery     (out_in_recovery),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  newreno_window_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_oldest_unacked   (in_oldest_unacked),
    .in_prior_unacked    (in_prior_unacked),
    .in_highest_sent     (in_highest_sent),
    .in_peer_window      (in_peer_window),
    .in_dup_count        (in_dup_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_bytes    (out_window_bytes),
    .out_threshold_bytes (out_threshold_bytes),
    .out_retransmit_now  (out_retransmit_now),
    .out_restart_timer   (out_restart_timer),
    .out_in_recovery     (out_in_recovery),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("newreno_congestion_window_top: mismatch");
      $finish;
    end
  end

  initial begin : drive_stall
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [WORD_W-1:0] seg_unit();
    return (seg_bytes == '0) ? 32'd1 : WORD_W'(seg_bytes);
  endfunction

  function automatic logic [WORD_W-1:0] advertised_window();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    return seg_unit() * $urandom_range(2, 64);
  endfunction

  // Valid stays high across back-to-back beats; it only drops for a gap or in settle().
  task automatic send_event(input logic [OP_W-1:0] op,
                            input logic [WORD_W-1:0] una,
                            input logic [WORD_W-1:0] first,
                            input logic [WORD_W-1:0] smax,
                            input logic [WORD_W-1:0] pwnd,
                            input logic [DUP_W-1:0] dups);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_oldest_unacked <= una;
    in_prior_unacked  <= first;
    in_highest_sent   <= smax;
    in_peer_window    <= pwnd;
    in_dup_count      <= dups;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic ack_new(input logic [WORD_W-1:0] adv);
    logic [WORD_W-1:0] prev_una;
    logic [WORD_W-1:0] unit;
    unit = seg_unit();
    prev_una = acked_upto;
    acked_upto = acked_upto + adv;
    if ($signed(sent_upto - acked_upto) < $signed(32'd2 * unit)) begin
      sent_upto = acked_upto + unit * $urandom_range(4, 24);
    end else begin
      sent_upto = sent_upto + unit * $urandom_range(0, 2);
    end
    send_event(OP_NEW_ACK, acked_upto, prev_una, sent_upto, advertised_window(), '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [MSS_W-1:0] mss, input logic [THR_W-1:0] thr);
    settle();
    write_reg(REG_MSS, CFG_W'(mss));
    // Upper data bits are junk for the threshold register and must be dropped.
    write_reg(REG_DUPTHR, {(CFG_W-THR_W)'($urandom), thr});
    seg_bytes   = mss;
    dup_trigger = thr;
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned       stop_at;
    int unsigned       pick;
    int unsigned       reps;
    logic [WORD_W-1:0] unit;
    logic [WORD_W-1:0] entry_max;
    logic [WORD_W-1:0] room;
    logic [WORD_W-1:0] adv;
    logic [WORD_W-1:0] prev_una;
    logic [DUP_W-1:0]  dups_hi;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      unit = seg_unit();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          if ($urandom_range(0, 3) == 0) begin
            ack_new($urandom_range(1, unit));
          end else begin
            ack_new(unit * $urandom_range(1, 3));
          end
        end
      end else if (pick < 75) begin
        // Loss episode: fresh ACK, duplicate run, partial ACKs, then a full
        // ACK or sometimes a timeout.
        ack_new(unit);
        dups_hi = DUP_W'(dup_trigger) + DUP_W'($urandom_range(0, 4));
        for (int d = 1; d <= dups_hi; d++) begin
          send_event(OP_DUP_ACK, acked_upto, acked_upto, sent_upto, advertised_window(),
                     DUP_W'(d));
        end
        entry_max = sent_upto;
        reps = $urandom_range(0, 3);
        repeat (reps) begin
          room = entry_max - acked_upto;
          if (room > 32'd1) begin
            adv = $urandom_range(1, (room - 32'd1 < 32'd3 * unit) ? room - 32'd1 : 32'd3 * unit);
            prev_una = acked_upto;
            acked_upto = acked_upto + adv;
            sent_upto = sent_upto + unit * $urandom_range(0, 2);
            send_event(OP_NEW_ACK, acked_upto, prev_una, sent_upto, advertised_window(), '0);
            if ($urandom_range(0, 2) == 0) begin
              send_event(OP_DUP_ACK, acked_upto, acked_upto, sent_upto, advertised_window(),
                         dups_hi + DUP_W'(1));
            end
          end
        end
        if ($urandom_range(0, 5) == 0) begin
          send_event(OP_TIMEOUT, acked_upto, acked_upto, sent_upto, advertised_window(), '0);
        end else begin
          prev_una = acked_upto;
          acked_upto = entry_max;
          send_event(OP_NEW_ACK, acked_upto, prev_una, sent_upto, advertised_window(), '0);
        end
      end else if (pick < 83) begin
        send_event(OP_TIMEOUT, acked_upto, acked_upto, sent_upto, advertised_window(), '0);
      end else begin
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          send_event(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 1) == 0) ? DUP_W'($urandom_range(0, 65535))
                                                 : DUP_W'(dup_trigger) +
                                                   DUP_W'($urandom_range(0, 2)));
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow start, then a full fast recovery cycle at the reset settings.
    send_event(OP_NEW_ACK, 32'd1000, 32'd0, 32'd20000, 32'hFFFF_FFFF, '0);
    send_event(OP_DUP_ACK, 32'd1000, 32'd1000, 32'd20000, 32'd64000, 16'd1);
    send_event(OP_DUP_ACK, 32'd1000, 32'd1000, 32'd20000, 32'd64000, 16'd3);
    send_event(OP_DUP_ACK, 32'd1000, 32'd1000, 32'd21000, 32'd64000, 16'd4);
    send_event(OP_NEW_ACK, 32'd5000, 32'd1000, 32'd21000, 32'd64000, '0);
    // Partial ACK larger than the window deflates it to zero, then adds back one MSS.
    send_event(OP_NEW_ACK, 32'd6000, 32'd6000 - 32'h1000_0000, 32'd21000, 32'd64000, '0);
    send_event(OP_NEW_ACK, 32'd6100, 32'd6000, 32'd21000, 32'd64000, '0);
    send_event(OP_NEW_ACK, 32'd20000, 32'd6100, 32'd21000, 32'd64000, '0);
    // Threshold hit again without passing the recovery point: no new entry.
    send_event(OP_DUP_ACK, 32'd20000, 32'd20000, 32'd21000, 32'd64000, 16'd3);
    send_event(OP_DUP_ACK, 32'd20000, 32'd20000, 32'd21000, 32'd64000, 16'hFFFF);
    send_event(OP_TIMEOUT, 32'd20000, 32'd20000, 32'd30000, 32'hFFFF_FFFF, '0);
    send_event(OP_UNUSED, '1, '1, '1, '1, '1);
    for (int k = 1; k <= 6; k++) begin
      send_event(OP_NEW_ACK, 20000 + k * 1460, 20000 + (k - 1) * 1460, 32'd40000,
                 32'hFFFF_FFFF, '0);
    end
    send_event(OP_NEW_ACK, '0, '0, '0, '0, '0);
    send_event(OP_NEW_ACK, '1, '1, '1, '1, '1);
    // Full ACK whose flight estimate saturates.
    send_event(OP_NEW_ACK, 32'd100, 32'd0, 32'd200, 32'd64000, '0);
    send_event(OP_DUP_ACK, 32'd100, 32'd100, 32'h8000_0000, 32'hFFFF_FFFF, 16'd3);
    send_event(OP_NEW_ACK, 32'h8000_0000, 32'd100, 32'h7FFF_FFF0, 32'd64000, '0);
    send_event(OP_TIMEOUT, 32'h8000_0000, 32'h8000_0000, 32'h8000_1000, 32'd0, '0);

    acked_upto = $urandom;
    sent_upto  = acked_upto + 32'd20 * seg_unit();
    run_traffic(120);

    set_config(16'hFFFF, 4'd15);
    run_traffic(90);

    set_config(16'd1, 4'd1);
    run_traffic(90);

    // Zero MSS and zero threshold: the window can reach zero and avoidance
    // must still grow it by one byte.
    set_config(16'd0, 4'd0);
    send_event(OP_TIMEOUT, acked_upto, acked_upto, sent_upto, 32'd1, '0);
    ack_new(32'd1);
    send_event(OP_DUP_ACK, acked_upto, acked_upto, sent_upto, 32'd0, '0);
    run_traffic(40);

    set_config(MSS_W'($urandom_range(1, 65535)), THR_W'($urandom_range(1, 15)));
    run_traffic(50);
    settle();
    run_traffic(50);

    gaps_on <= 1'b0;
    set_config(16'd536, 4'd2);
    run_traffic(80);

    settle();
    if (fail_count == 0) begin
      $display("newreno_congestion_window_top: match");
    end else begin
      $display("newreno_congestion_window_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nrcw_pkg.sv
rtl/nrcw_div.sv
rtl/newreno_congestion_window_top.sv
tb/newreno_window_checker.sv
tb/tb_top.sv
